/* sv/recurrence_byte_checksum_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef RECURRENCE_BYTE_CHECKSUM_TOP_MACROS_SVH
`define RECURRENCE_BYTE_CHECKSUM_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define RBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rbc_pkg.sv */
package rbc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 16;
  localparam int unsigned SUM_W = BYTE_W + 1;
  localparam int unsigned PLUS_W = SUM_W + TERM_W;
  localparam int unsigned MINUS_W = BYTE_W + TERM_W;

  localparam logic [BYTE_W-1:0] ALPHA_MUL = 8'd17;
  localparam logic [BYTE_W-1:0] BETA_MUL = 8'd31;
  localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
  localparam logic [TERM_W-1:0] OLDER_START = 16'd1;
  localparam logic [TERM_W-1:0] NEWER_RESET = 16'd1;
  localparam logic [TERM_W:0] CK_MOD = 17'd65535;
  // 65535 * 256 + 1: keeps a negative difference in range, but adds a residue of 1 modulo 65535.
  localparam logic [PLUS_W:0] NEG_BIAS = 26'd16776961;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } item_t;

endpackage

/* sv/rbc_in_reg.sv */
module rbc_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // data_byte
  input  logic                       s_axis_tuser,  // first_byte
  input  logic                       s_axis_tlast,  // last_byte
  input  logic                       take,
  output logic                       item_valid,
  output rbc_pkg::item_t             item
);
  import rbc_pkg::*;

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.data_byte  <= s_axis_tdata;
      item.first_byte <= s_axis_tuser;
      item.last_byte  <= s_axis_tlast;
    end
  end

endmodule

/* sv/rbc_term.sv */
module rbc_term (
  input  logic [rbc_pkg::BYTE_W-1:0] data_byte,
  input  logic [rbc_pkg::BYTE_W-1:0] pos,
  input  logic [rbc_pkg::TERM_W-1:0] newer,
  input  logic [rbc_pkg::TERM_W-1:0] older,
  output logic [rbc_pkg::TERM_W-1:0] term
);
  import rbc_pkg::*;

  logic [BYTE_W-1:0]  alpha;
  logic [BYTE_W-1:0]  beta;
  logic [SUM_W-1:0]   sum;
  logic [PLUS_W-1:0]  plus;
  logic [MINUS_W-1:0] minus;
  logic               neg;
  logic [PLUS_W:0]    diff;
  logic [TERM_W:0]    fold;

  assign alpha = BYTE_W'(pos * ALPHA_MUL);
  assign beta  = BYTE_W'(pos * BETA_MUL);
  assign sum   = {1'b0, data_byte} + {1'b0, alpha};
  assign plus  = PLUS_W'(sum) * PLUS_W'(newer);
  assign minus = MINUS_W'(beta) * MINUS_W'(older);
  assign neg   = plus < PLUS_W'(minus);

  // The biased difference stays below 2^25, so one fold and one subtract finish the modulo.
  assign diff = {1'b0, plus} - (PLUS_W + 1)'(minus) + (neg ? NEG_BIAS : '0);
  assign fold = {1'b0, diff[TERM_W-1:0]} + (TERM_W + 1)'(diff[PLUS_W-1:TERM_W]);
  assign term = (fold >= CK_MOD) ? TERM_W'(fold - CK_MOD) : fold[TERM_W-1:0];

endmodule

/* sv/recurrence_byte_checksum_top.sv */
// A checksum is registered on the output when its final byte leaves the input register;
// the recurrence is computed while that byte sits in the input register.
// Throughput: one byte per cycle through two narrow multipliers and a folded modulo 65535;
// only a final byte waits, and only while an earlier checksum is stalled on the output.
// Reset (rst, synchronous, active high) empties both registers, sets the position to 0
// and both terms to 1.
module recurrence_byte_checksum_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // first_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // checksum
);
  import rbc_pkg::*;

  logic              item_valid;
  item_t             item;
  logic              take;
  logic [BYTE_W-1:0] byte_position;
  logic [BYTE_W-1:0] pos_next;
  logic [TERM_W-1:0] older_term;
  logic [TERM_W-1:0] newer_term;
  logic [TERM_W-1:0] term;
  logic [TERM_W-1:0] newer_next;

  rbc_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  assign pos_next = byte_position + BYTE_W'(1);

  rbc_term u_term (
    .data_byte (item.data_byte),
    .pos       (pos_next),
    .newer     (newer_term),
    .older     (older_term),
    .term      (term)
  );

  // A byte that ends no message never waits on the result side.
  assign take = item_valid && (!item.last_byte || !m_axis_tvalid || m_axis_tready);

  assign newer_next = item.first_byte ? TERM_W'(item.data_byte) + FIRST_OFFSET : term;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      older_term    <= OLDER_START;
      newer_term    <= NEWER_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        if (item.first_byte) begin
          byte_position <= '0;
          older_term    <= OLDER_START;
        end else begin
          byte_position <= pos_next;
          older_term    <= newer_term;
        end
        newer_term <= newer_next;
      end
      if (take && item.last_byte) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      m_axis_tdata <= newer_next;
    end
  end

endmodule

/* sv/rbc_checker.sv */
`include "recurrence_byte_checksum_top_macros.svh"

module rbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled checksum stays on the bus unchanged.
  `RBC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled checksum changed or dropped")

  // A reduced term never reaches the modulus itself.
  `RBC_ASSERT(a_out_range, m_axis_tvalid |-> m_axis_tdata != 16'hFFFF, "checksum out of range")

  // Reset leaves no checksum pending.
  `RBC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_axis_tvalid, "checksum pending after reset")

  // With the result side free, the block always takes a request.
  `RBC_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input blocked while output empty")

endmodule

bind recurrence_byte_checksum_top rbc_checker u_rbc_checker (.*);
